@@ hw/rtl/bitmap_page_allocator_macros.svh @@
// Assertion helpers for the page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page allocator check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page allocator check failed");

`endif

@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned MAP_WORDS  = PAGE_COUNT / WORD_BITS;
  localparam int unsigned ADDR_W     = $clog2(MAP_WORDS);
  localparam int unsigned OFF_W      = $clog2(WORD_BITS);
  localparam int unsigned POS_W      = 14;
  localparam int unsigned ALIGN_W    = 12;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(1);

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    logic load;
    logic clash;
    logic adv;
    logic mark;
    logic wr;
    logic clr;
    logic fail;
  } bpa_cmd_t;

  typedef struct packed {
    action_e act;
    logic    bad_count;
    logic    range_empty;
    logic    used_any;
    logic    last_word;
    logic    fit_fail;
  } bpa_sts_t;

endpackage

@@ hw/rtl/bitmap_page_allocator.sv @@
// Channel   | Direction | Signals                                   | Handshake
// ----------+-----------+-------------------------------------------+--------------------------
// command   | in        | action_i, page_index_i, count_i           | start & !busy
// result    | out       | start_page_o, failed_o                    | result_valid_o, 1 cycle
// config    | in        | cfg_data_i (align_mask)                   | cfg_valid_i & cfg_ready_o
//
// Steps: allocate reads and checks each bitmap word inspected (a clash restarts the
//   scan at the next aligned start), then reads and rewrites each word marked; free
//   reads and rewrites each word touched; clear and unknown actions end at decode.
//   The single-port bitmap memory's registered read puts a read before each use.
// Reset: the map reads all free at once via per-word valid flags; no sweep.
// Stalls: none; busy stays high until the cycle after the result strobe.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [11:0]        page_index_i,
  input  logic [12:0]        count_i,
  output logic               result_valid_o,
  output logic [12:0]        start_page_o,
  output logic               failed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ALIGN_W-1:0] cfg_data_i
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  // the user must write config only while idle; the block does not enforce it, so always take it
  assign cfg_ready_o = 1'b1;

  // controller: sequences decode, scan, and read-modify-write of map words
  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  // datapath: bitmap memory, search pointers, alignment register, result
  bpa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .page_index_i (page_index_i),
    .count_i      (count_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_page_o (start_page_o),
    .failed_o     (failed_o)
  );

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  bpa_sts_t sts_i,
  output bpa_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DEC  = 7'b0000010,
    ST_RD   = 7'b0000100,
    ST_CHK  = 7'b0001000,
    ST_MRD  = 7'b0010000,
    ST_MWR  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        case (sts_i.act)
          ACT_ALLOC: begin
            if (sts_i.bad_count) begin
              cmd_o.fail = 1'b1;
              state_d    = ST_DONE;
            end else begin
              state_d = ST_RD;
            end
          end
          ACT_FREE: begin
            state_d = sts_i.range_empty ? ST_DONE : ST_MRD;
          end
          ACT_CLEAR: begin
            cmd_o.clr = 1'b1;
            state_d   = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        if (sts_i.used_any) begin
          cmd_o.clash = 1'b1;
          if (sts_i.fit_fail) begin
            cmd_o.fail = 1'b1;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_RD;
          end
        end else if (sts_i.last_word) begin
          cmd_o.mark = 1'b1;
          state_d    = ST_MRD;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_RD;
        end
      end
      ST_MRD: state_d = ST_MWR;
      ST_MWR: begin
        cmd_o.wr = 1'b1;
        if (sts_i.last_word) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_MRD;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

@@ hw/rtl/bpa_datapath.sv @@
module bpa_datapath import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ALIGN_W-1:0] cfg_data_i,
  input  logic [1:0]         action_i,
  input  logic [11:0]        page_index_i,
  input  logic [12:0]        count_i,
  input  bpa_cmd_t           cmd_i,
  output bpa_sts_t           sts_o,
  output logic [12:0]        start_page_o,
  output logic               failed_o
);

  localparam logic [POS_W-1:0] PAGES = POS_W'(PAGE_COUNT);

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;

  logic [ALIGN_W-1:0] align_q;
  action_e            act_q;
  logic [12:0]        count_q;
  logic [POS_W-1:0]   s_q, p_q, e_q;
  logic               fail_q;

  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] rd_eff, lo_mask, hi_mask, mask, used, wdata;
  logic [OFF_W-1:0]     hit_idx;
  logic [POS_W-1:0]     hit_pos, s_new, next_word, free_end, align_ext;
  logic [POS_W:0]       s_end;

  assign waddr   = p_q[OFF_W +: ADDR_W];
  assign rd_eff  = rvld_q ? rdata_q : '0;
  assign lo_mask = {WORD_BITS{1'b1}} << p_q[OFF_W-1:0];
  assign hi_mask = (e_q[POS_W-1:OFF_W] == p_q[POS_W-1:OFF_W])
                 ? ((WORD_BITS'(1) << e_q[OFF_W-1:0]) - WORD_BITS'(1))
                 : {WORD_BITS{1'b1}};
  assign mask    = lo_mask & hi_mask;
  assign used    = rd_eff & mask;

  // lowest used page in the window
  always_comb begin
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (used[b]) hit_idx = OFF_W'(b);
    end
  end

  assign align_ext = POS_W'(align_q);
  assign hit_pos   = {p_q[POS_W-1:OFF_W], hit_idx};
  assign s_new     = (hit_pos + POS_W'(1) + align_ext) & ~align_ext;
  assign s_end     = {1'b0, s_new} + (POS_W+1)'(count_q);
  assign next_word = {p_q[POS_W-1:OFF_W] + (POS_W-OFF_W)'(1), OFF_W'(0)};
  assign free_end  = POS_W'(page_index_i) + POS_W'(count_i);
  assign wdata     = (act_q == ACT_ALLOC) ? (rd_eff | mask) : (rd_eff & ~mask);

  assign sts_o.act         = act_q;
  assign sts_o.bad_count   = (count_q == '0) || (POS_W'(count_q) > PAGES);
  assign sts_o.range_empty = (p_q >= e_q);
  assign sts_o.used_any    = |used;
  assign sts_o.last_word   = (next_word >= e_q);
  assign sts_o.fit_fail    = (s_end > (POS_W+1)'(PAGE_COUNT));

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[waddr];
    if (cmd_i.wr) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      align_q <= ALIGN_RESET;
      act_q   <= ACT_NONE;
      fail_q  <= 1'b0;
    end else begin
      rvld_q <= vld_q[waddr];
      if (cfg_we_i) align_q <= cfg_data_i;
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.wr) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.load) begin
        act_q  <= action_e'(action_i);
        fail_q <= 1'b0;
      end else if (cmd_i.fail) begin
        fail_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= count_i;
      s_q     <= '0;
      if (action_e'(action_i) == ACT_FREE) begin
        p_q <= POS_W'(page_index_i);
        e_q <= (free_end > PAGES) ? PAGES : free_end;
      end else begin
        p_q <= '0;
        e_q <= POS_W'(count_i);
      end
    end else if (cmd_i.clash) begin
      s_q <= s_new;
      p_q <= s_new;
      e_q <= s_end[POS_W-1:0];
    end else if (cmd_i.mark) begin
      p_q <= s_q;
    end else if (cmd_i.adv) begin
      p_q <= next_word;
    end
  end

  assign start_page_o = (act_q != ACT_ALLOC) ? 13'd0
                      : (fail_q ? 13'(PAGE_COUNT) : s_q[12:0]);
  assign failed_o     = fail_q;

endmodule

@@ hw/rtl/bpa_checker.sv @@
`include "bitmap_page_allocator_macros.svh"

module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [12:0] start_page_o,
  input logic        failed_o
);

  // an accepted transaction occupies the block
  `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // the strobe lasts one cycle and frees the block
  `BPA_ASSERT_NEXT(a_strobe_ends, result_valid_o, !result_valid_o && !busy)
  // a result only appears while a transaction is in flight
  `BPA_ASSERT_NOW(a_strobe_busy, result_valid_o, busy)
  // a failed allocation reports the page count
  `BPA_ASSERT_NOW(a_fail_page, result_valid_o && failed_o, start_page_o == 13'd4096)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .start_page_o   (start_page_o),
  .failed_o       (failed_o)
);
